// ===== src/pbpm_pkg.sv =====
// Shared types, codes and arithmetic helpers for the pitch band peak meter.
`timescale 1ns / 1ps

package pbpm_pkg;

    localparam int BANDS    = 16;
    localparam int BAND_W   = $clog2(BANDS);
    localparam int PEAK_W   = 7;
    localparam int PITCH_W  = 7;
    localparam int CNT_W    = 8;

    localparam logic [CNT_W-1:0]   INTERVAL_RST = 8'd10;
    localparam logic [PITCH_W-1:0] PITCH_LO     = 7'd12;
    localparam logic [PITCH_W-1:0] PITCH_HI     = 7'd107;
    localparam logic [PITCH_W-1:0] HALF_OCT     = 7'd6;

    typedef enum logic [1:0] {
        CMD_IN_NOTE  = 2'd0,
        CMD_OUT_NOTE = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    // controller -> datapath
    typedef struct packed {
        logic              accept;    // input beat taken this cycle
        logic              decay_en;  // decay sweep writes this cycle
        logic [BAND_W-1:0] decay_idx; // band being decayed
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic tick_fire;              // current input is a tick that fires decay
    } t_dp_stat;

    // Pitch to band: clamp, octave via reciprocal multiply, half-octave bit.
    function automatic logic [BAND_W-1:0] pitch_to_band(input logic [PITCH_W-1:0] pitch);
        logic [PITCH_W-1:0] p;
        logic [PITCH_W-1:0] q;
        logic [12:0]        prod;
        logic [2:0]         oct;
        logic [PITCH_W-1:0] rem;
        p = pitch;
        if (p < PITCH_LO) p = PITCH_LO;
        if (p > PITCH_HI) p = PITCH_HI;
        q    = p - PITCH_LO;
        prod = {6'd0, q} * 13'd43;              // floor(q/12) for q <= 95
        oct  = prod[11:9];
        rem  = q - ({4'd0, oct} * 7'd12);
        return {oct, (rem >= HALF_OCT)};
    endfunction

    // floor(x*19/20) via reciprocal multiply, exact for 7-bit x.
    function automatic logic [PEAK_W-1:0] decay_peak(input logic [PEAK_W-1:0] x);
        logic [11:0] y;
        logic [23:0] p;
        y = {5'd0, x} * 12'd19;
        p = {12'd0, y} * 24'd3277;
        return p[22:16];
    endfunction

endpackage

// ===== src/pbpm_ctrl.sv =====
// Controller: handshake, output valid and decay sweep sequencing.
`timescale 1ns / 1ps

module pbpm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  pbpm_pkg::t_dp_stat  i_stat,
    output pbpm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_DECAY
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_out_valid, n_out_valid;
    logic [pbpm_pkg::BAND_W-1:0]  r_idx, n_idx;
    logic                         accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept    = accept;
    assign o_cmd.decay_en  = (r_state == S_DECAY);
    assign o_cmd.decay_idx = r_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (accept) n_out_valid = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.tick_fire) begin
                    n_state = S_DECAY;
                    n_idx   = '0;
                end
            end
            S_DECAY: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == pbpm_pkg::BAND_W'(pbpm_pkg::BANDS - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

endmodule

// ===== src/pbpm_datapath.sv =====
// Datapath: peak registers, decay counter, interval register and result register.
`timescale 1ns / 1ps

module pbpm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pbpm_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [1:0]                    i_command,
    input  logic [pbpm_pkg::PITCH_W-1:0]  i_note_pitch,
    input  logic [pbpm_pkg::PEAK_W-1:0]   i_note_velocity,
    input  logic                          i_read_meter,
    input  logic [pbpm_pkg::BAND_W-1:0]   i_read_band,
    input  pbpm_pkg::t_dp_cmd             i_cmd,
    output pbpm_pkg::t_dp_stat            o_stat,
    output logic [pbpm_pkg::BAND_W-1:0]   o_band_index,
    output logic [pbpm_pkg::PEAK_W-1:0]   o_peak_value,
    output logic                          o_decay_fired
);

    logic [pbpm_pkg::PEAK_W-1:0] r_in_peaks  [pbpm_pkg::BANDS];
    logic [pbpm_pkg::PEAK_W-1:0] r_out_peaks [pbpm_pkg::BANDS];
    logic [pbpm_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pbpm_pkg::CNT_W-1:0]  r_interval;
    logic [pbpm_pkg::BAND_W-1:0] r_band;
    logic [pbpm_pkg::PEAK_W-1:0] r_peak;
    logic                        r_fired;

    pbpm_pkg::t_cmd              cmd;
    logic                        is_note, is_tick;
    logic [pbpm_pkg::BAND_W-1:0] note_band;
    logic [pbpm_pkg::BAND_W-1:0] rd_idx;
    logic                        rd_meter;
    logic [pbpm_pkg::PEAK_W-1:0] rd_old;
    logic [pbpm_pkg::PEAK_W-1:0] note_peak;
    logic [pbpm_pkg::CNT_W:0]    cnt_next;
    logic                        fire;
    logic                        note_wr;

    assign cmd       = pbpm_pkg::t_cmd'(i_command);
    assign is_note   = (cmd == pbpm_pkg::CMD_IN_NOTE) || (cmd == pbpm_pkg::CMD_OUT_NOTE);
    assign is_tick   = (cmd == pbpm_pkg::CMD_TICK);
    assign note_band = pbpm_pkg::pitch_to_band(i_note_pitch);

    // one read address per cycle: sweep index, read band or note band
    always_comb begin
        if (i_cmd.decay_en) begin
            rd_idx   = i_cmd.decay_idx;
            rd_meter = 1'b0;
        end else if (cmd == pbpm_pkg::CMD_READ) begin
            rd_idx   = i_read_band;
            rd_meter = i_read_meter;
        end else begin
            rd_idx   = note_band;
            rd_meter = (cmd == pbpm_pkg::CMD_OUT_NOTE);
        end
    end

    assign rd_old    = rd_meter ? r_out_peaks[rd_idx] : r_in_peaks[rd_idx];
    assign note_peak = (i_note_velocity > rd_old) ? i_note_velocity : rd_old;
    assign note_wr   = i_cmd.accept && is_note && !i_cmd.decay_en;

    assign cnt_next  = {1'b0, r_count} + 1'b1;
    assign fire      = cnt_next > {1'b0, r_interval};
    assign o_stat.tick_fire = is_tick && fire;

    always_comb begin
        n_count = r_count;
        if (i_cmd.accept && is_tick) begin
            n_count = fire ? '0 : cnt_next[pbpm_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_interval <= pbpm_pkg::INTERVAL_RST;
            for (int i = 0; i < pbpm_pkg::BANDS; i++) begin
                r_in_peaks[i]  <= '0;
                r_out_peaks[i] <= '0;
            end
        end else begin
            r_count <= n_count;
            if (i_cfg_we) r_interval <= i_cfg_wdata;
            if (i_cmd.decay_en) begin
                r_in_peaks[rd_idx]  <= pbpm_pkg::decay_peak(r_in_peaks[rd_idx]);
                r_out_peaks[rd_idx] <= pbpm_pkg::decay_peak(r_out_peaks[rd_idx]);
            end else if (note_wr) begin
                if (rd_meter) r_out_peaks[rd_idx] <= note_peak;
                else          r_in_peaks[rd_idx]  <= note_peak;
            end
        end
    end

    // result register, loaded on every accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            case (cmd)
                pbpm_pkg::CMD_IN_NOTE, pbpm_pkg::CMD_OUT_NOTE: begin
                    r_band  <= rd_idx;
                    r_peak  <= note_peak;
                    r_fired <= 1'b0;
                end
                pbpm_pkg::CMD_TICK: begin
                    r_band  <= '0;
                    r_peak  <= '0;
                    r_fired <= fire;
                end
                default: begin
                    r_band  <= rd_idx;
                    r_peak  <= rd_old;
                    r_fired <= 1'b0;
                end
            endcase
        end
    end

    assign o_band_index  = r_band;
    assign o_peak_value  = r_peak;
    assign o_decay_fired = r_fired;

endmodule

// ===== src/pitch_band_peak_meter_core.sv =====
// Top level of the pitch band peak meter: controller plus datapath.
`timescale 1ns / 1ps
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle for notes, reads and non-firing ticks while the
//   receiver takes results; a tick that fires the decay is followed by a sweep
//   (one band of both meters per cycle, one decay unit per meter); no beat is taken.
// Reset (i_rst_n low, synchronous): all peaks and the tick counter clear,
//   decay_interval returns to 10, output valid drops.

module pitch_band_peak_meter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: decay_interval
    input  logic                          i_cfg_we,
    input  logic [pbpm_pkg::CNT_W-1:0]    i_cfg_wdata,
    // input beat
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [pbpm_pkg::PITCH_W-1:0]  i_note_pitch,
    input  logic [pbpm_pkg::PEAK_W-1:0]   i_note_velocity,
    input  logic                          i_read_meter,
    input  logic [pbpm_pkg::BAND_W-1:0]   i_read_band,
    // result beat
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pbpm_pkg::BAND_W-1:0]   o_band_index,
    output logic [pbpm_pkg::PEAK_W-1:0]   o_peak_value,
    output logic                          o_decay_fired
);

    pbpm_pkg::t_dp_cmd  dp_cmd;
    pbpm_pkg::t_dp_stat dp_stat;

    // Controller: owns the handshake, the output valid flag and the sweep index.
    pbpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Datapath: peak registers, band mapping, decay math and result register.
    pbpm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_note_pitch    (i_note_pitch),
        .i_note_velocity (i_note_velocity),
        .i_read_meter    (i_read_meter),
        .i_read_band     (i_read_band),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_band_index    (o_band_index),
        .o_peak_value    (o_peak_value),
        .o_decay_fired   (o_decay_fired)
    );

    // A firing tick must start the sweep, which blocks new beats.
    a_fire_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.accept && dp_stat.tick_fire |=> !o_in_ready && dp_cmd.decay_en)
        else $error("firing tick did not start decay sweep");

    // Every accepted beat yields a pending result next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat produced no result");

    // A decay result carries no band or peak.
    a_fire_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decay_fired |-> o_band_index == '0 && o_peak_value == '0)
        else $error("decay result with nonzero band or peak");

    // The sweep never overlaps an accepted beat.
    a_sweep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.decay_en |-> !dp_cmd.accept)
        else $error("beat accepted during decay sweep");

endmodule

// ===== dv/pitch_band_peak_meter_core_test.sv =====
// Self-checking testbench for the pitch band peak meter core.
`timescale 1ns / 1ps

module pitch_band_peak_meter_core_test;

    // Cycles without any beat before the run is declared hung. The slowest
    // legal stretch is a long receiver hold-off (HOLD_CYCLES) plus sender and
    // receiver gaps and a decay sweep, so this limit leaves a wide margin.
    localparam int STALL_LIMIT  = 2000;
    // Long receiver hold-off used to fill the block and back up its input.
    localparam int HOLD_CYCLES  = 60;
    // Quiet cycles after the last result: covers the decay sweep that a
    // firing tick starts, which may still run after its result has left.
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_GAP      = 8;

    typedef struct {
        logic [pbpm_pkg::BAND_W-1:0] band;
        logic [pbpm_pkg::PEAK_W-1:0] peak;
        logic                        fired;
    } t_meter_result;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_cfg_we        = 1'b0;
    logic [pbpm_pkg::CNT_W-1:0]   i_cfg_wdata     = '0;
    logic                         i_in_valid      = 1'b0;
    logic                         o_in_ready;
    logic [1:0]                   i_command       = pbpm_pkg::CMD_READ;
    logic [pbpm_pkg::PITCH_W-1:0] i_note_pitch    = '0;
    logic [pbpm_pkg::PEAK_W-1:0]  i_note_velocity = '0;
    logic                         i_read_meter    = 1'b0;
    logic [pbpm_pkg::BAND_W-1:0]  i_read_band     = '0;
    logic                         o_out_valid;
    logic                         i_out_ready     = 1'b0;
    logic [pbpm_pkg::BAND_W-1:0]  o_band_index;
    logic [pbpm_pkg::PEAK_W-1:0]  o_peak_value;
    logic                         o_decay_fired;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pitch_band_peak_meter_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_note_pitch    (i_note_pitch),
        .i_note_velocity (i_note_velocity),
        .i_read_meter    (i_read_meter),
        .i_read_band     (i_read_band),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_band_index    (o_band_index),
        .o_peak_value    (o_peak_value),
        .o_decay_fired   (o_decay_fired)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of both meters, the tick counter and
    // the decay interval register.
    // ------------------------------------------------------------------
    logic [pbpm_pkg::PEAK_W-1:0] in_peak_mem  [pbpm_pkg::BANDS];
    logic [pbpm_pkg::PEAK_W-1:0] out_peak_mem [pbpm_pkg::BANDS];
    logic [pbpm_pkg::CNT_W-1:0]  tick_count;
    logic [pbpm_pkg::CNT_W-1:0]  interval_reg;

    t_meter_result     pending_results[$];
    int                err_count   = 0;
    bit                idle_on     = 1'b1;  // random gaps on both sides
    bit                hold_req    = 1'b0;  // ask the receiver for a long hold-off

    initial begin
        foreach (in_peak_mem[i]) begin
            in_peak_mem[i]  = '0;
            out_peak_mem[i] = '0;
        end
        tick_count   = '0;
        interval_reg = pbpm_pkg::INTERVAL_RST;
    end

    // Apply one accepted beat to the predicted state and return the result
    // the block should produce for it.
    function automatic t_meter_result predict_meter_beat(
        pbpm_pkg::t_cmd               cmd,
        logic [pbpm_pkg::PITCH_W-1:0] pitch,
        logic [pbpm_pkg::PEAK_W-1:0]  vel,
        logic                         meter,
        logic [pbpm_pkg::BAND_W-1:0]  rband
    );
        t_meter_result r;
        int            p;
        int            b;
        int            i;
        int            d;
        r.band  = '0;
        r.peak  = '0;
        r.fired = 1'b0;
        case (cmd)
            pbpm_pkg::CMD_IN_NOTE, pbpm_pkg::CMD_OUT_NOTE: begin
                // clamp pitch to 12..107, two bands per octave
                p = pitch;
                if (p < 12) p = 12;
                if (p > 107) p = 107;
                b = ((p - 12) / 12) * 2 + (((p % 12) >= 6) ? 1 : 0);
                if (b > pbpm_pkg::BANDS - 1) b = pbpm_pkg::BANDS - 1;
                r.band = b[pbpm_pkg::BAND_W-1:0];
                if (cmd == pbpm_pkg::CMD_IN_NOTE) begin
                    if (in_peak_mem[b] < vel) in_peak_mem[b] = vel;
                    r.peak = in_peak_mem[b];
                end else begin
                    if (out_peak_mem[b] < vel) out_peak_mem[b] = vel;
                    r.peak = out_peak_mem[b];
                end
            end
            pbpm_pkg::CMD_TICK: begin
                // compare the incremented count without wrapping at 8 bits
                if (int'(tick_count) + 1 > int'(interval_reg)) begin
                    for (i = 0; i < pbpm_pkg::BANDS; i++) begin
                        d = (int'(in_peak_mem[i]) * 19) / 20;
                        in_peak_mem[i]  = d[pbpm_pkg::PEAK_W-1:0];
                        d = (int'(out_peak_mem[i]) * 19) / 20;
                        out_peak_mem[i] = d[pbpm_pkg::PEAK_W-1:0];
                    end
                    tick_count = '0;
                    r.fired    = 1'b1;
                end else begin
                    tick_count = tick_count + 1'b1;
                end
            end
            default: begin
                r.band = rband;
                r.peak = meter ? out_peak_mem[rband] : in_peak_mem[rband];
            end
        endcase
        return r;
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Sender: one input beat. Inputs move on the falling edge; acceptance
    // is seen on the rising edge. Valid is left high on return, so a
    // back-to-back beat only changes the payload.
    // ------------------------------------------------------------------
    task automatic send_beat(
        pbpm_pkg::t_cmd               cmd,
        logic [pbpm_pkg::PITCH_W-1:0] pitch,
        logic [pbpm_pkg::PEAK_W-1:0]  vel,
        logic                         meter,
        logic [pbpm_pkg::BAND_W-1:0]  rband
    );
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_note_pitch    <= pitch;
        i_note_velocity <= vel;
        i_read_meter    <= meter;
        i_read_band     <= rband;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.insert(pending_results.size(),
                               predict_meter_beat(cmd, pitch, vel, meter, rband));
    endtask

    // Random beat: half notes, a quarter ticks, a quarter reads. Unused
    // fields still carry random values.
    task automatic send_random_beat();
        int unsigned    sel;
        int unsigned    rp;
        int unsigned    rv;
        int unsigned    rm;
        int unsigned    rb;
        pbpm_pkg::t_cmd cmd;
        sel = $urandom_range(0, 7);
        if (sel < 2)      cmd = pbpm_pkg::CMD_IN_NOTE;
        else if (sel < 4) cmd = pbpm_pkg::CMD_OUT_NOTE;
        else if (sel < 6) cmd = pbpm_pkg::CMD_TICK;
        else              cmd = pbpm_pkg::CMD_READ;
        rp = $urandom_range(0, 127);
        rv = $urandom_range(0, 127);
        rm = $urandom_range(0, 1);
        rb = $urandom_range(0, pbpm_pkg::BANDS - 1);
        send_beat(cmd, rp[pbpm_pkg::PITCH_W-1:0], rv[pbpm_pkg::PEAK_W-1:0],
                  rm[0], rb[pbpm_pkg::BAND_W-1:0]);
    endtask

    // Drop valid, wait for every outstanding result, then let any decay
    // sweep finish so the block is truly idle.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_interval(logic [pbpm_pkg::CNT_W-1:0] value);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        interval_reg = value;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result beat, plus one long hold-off on
    // request, counted here rather than in the sender.
    // ------------------------------------------------------------------
    initial begin : ready_driver
        int unsigned wait_cycles;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            wait_cycles = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    // Result checker: each result beat against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_meter_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected beat band=%0d peak=%0d fired=%0b",
                                     o_band_index, o_peak_value, o_decay_fired));
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (o_band_index !== exp_r.band || o_peak_value !== exp_r.peak ||
                    o_decay_fired !== exp_r.fired) begin
                    flag_error($sformatf(
                        "exp band=%0d peak=%0d fired=%0b, got band=%0d peak=%0d fired=%0b",
                        exp_r.band, exp_r.peak, exp_r.fired,
                        o_band_index, o_peak_value, o_decay_fired));
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset contents, pitch clamping at both ends, band edges, velocity
    // zero, both meters, reads, and ticks below the default interval.
    task automatic test_directed();
        send_beat(pbpm_pkg::CMD_READ,     7'd0,   7'd0,   1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_READ,     7'd0,   7'd0,   1'b1, 4'd15);
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd0,   7'd127, 1'b0, 4'd0);   // low clamp
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd127, 7'd1,   1'b1, 4'd15);  // high clamp
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd11,  7'd5,   1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd12,  7'd0,   1'b0, 4'd0);   // zero velocity
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd17,  7'd64,  1'b0, 4'd0);   // last of band 0
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd18,  7'd90,  1'b0, 4'd0);   // first of band 1
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd107, 7'd100, 1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd108, 7'd3,   1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_IN_NOTE,  7'd66,  7'd45,  1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_OUT_NOTE, 7'd60,  7'd127, 1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_OUT_NOTE, 7'd66,  7'd0,   1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_OUT_NOTE, 7'd127, 7'd127, 1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_OUT_NOTE, 7'd5,   7'd1,   1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_READ,     7'd0,   7'd0,   1'b1, 4'd8);
        send_beat(pbpm_pkg::CMD_READ,     7'd0,   7'd0,   1'b0, 4'd15);
        send_beat(pbpm_pkg::CMD_READ,     7'd0,   7'd0,   1'b0, 4'd1);
        repeat (3) send_beat(pbpm_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0, 4'd0);
    endtask

    // Interval at both extremes, and an interval lowered below the count.
    task automatic test_interval_extremes();
        int          n;
        int unsigned rp;
        write_interval(8'd0);                 // every tick decays
        repeat (2) send_beat(pbpm_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0, 4'd0);
        send_beat(pbpm_pkg::CMD_READ, 7'd0, 7'd0, 1'b1, 4'd8);
        write_interval(8'd255);
        repeat (5) send_beat(pbpm_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0, 4'd0);
        write_interval(8'd3);                 // now below the count of 5
        send_beat(pbpm_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0, 4'd0);
        // Full 256-tick period at the top interval, no idling on either side;
        // the count must pass 255 before the decay fires.
        write_interval(8'd255);
        idle_on = 1'b0;
        for (n = 0; n < 257; n++) begin
            if (n % 32 == 0) begin
                rp = $urandom_range(0, 127);
                send_beat(pbpm_pkg::CMD_IN_NOTE, rp[pbpm_pkg::PITCH_W-1:0], 7'd127,
                          1'b0, 4'd0);
            end
            send_beat(pbpm_pkg::CMD_TICK, 7'd0, 7'd0, 1'b0, 4'd0);
        end
        idle_on = 1'b1;
    endtask

    // Random traffic under several interval settings, one phase without gaps.
    task automatic test_random_phases();
        logic [pbpm_pkg::CNT_W-1:0] settings [5];
        int                         ph;
        int unsigned                rv;
        settings[0] = 8'd1;
        rv = $urandom_range(0, 255);
        settings[1] = rv[pbpm_pkg::CNT_W-1:0];
        settings[2] = 8'd0;
        settings[3] = pbpm_pkg::INTERVAL_RST;
        rv = $urandom_range(2, 6);
        settings[4] = rv[pbpm_pkg::CNT_W-1:0];
        for (ph = 0; ph < 5; ph++) begin
            write_interval(settings[ph]);
            idle_on = (ph != 3);
            repeat (60) send_random_beat();
        end
        idle_on = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps going,
    // so the block fills and stalls its input; then the sender waits for
    // every result before going on.
    task automatic test_backpressure();
        write_interval(8'd4);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random_beat();
        idle_on  = 1'b1;
        quiesce();
        repeat (20) send_random_beat();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_interval_extremes();
        test_random_phases();
        test_backpressure();

        quiesce();
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
